>>> hw/rtl/bzsd_pkg.sv
// Shared types, constants and a helper function for the bright zone steering decider.
package bzsd_pkg;

    // Default parameter values.
    localparam int MAX_FRAME_DIM_DEF = 2048;
    localparam int FRACTION_BITS_DEF = 10;

    // Fixed field widths.
    localparam int PIXEL_W = 8;
    localparam int DIM_W   = 12;
    localparam int FRAC_W  = 11;
    localparam int COUNT_W = 23;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_COLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_FRAC  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_FRAC   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_CNT = 3'd7;

    // Register reset values.
    localparam logic [PIXEL_W-1:0] RST_BRIGHTNESS = 8'd175;
    localparam logic [DIM_W-1:0]   RST_TOP_ROWS   = 12'd120;
    localparam logic [DIM_W-1:0]   RST_SIDE_COLS  = 12'd180;
    localparam logic [DIM_W-1:0]   RST_WIDTH      = 12'd640;
    localparam logic [DIM_W-1:0]   RST_HEIGHT     = 12'd480;
    localparam logic [FRAC_W-1:0]  RST_SIDE_FRAC  = 11'd205;
    localparam logic [FRAC_W-1:0]  RST_TOP_FRAC   = 11'd205;
    localparam logic [COUNT_W-1:0] RST_MIDDLE_CNT = 23'd100800;

    // Steering command codes.
    typedef enum logic [3:0] {
        CMD_PIVOT_RIGHT      = 4'd0,
        CMD_PIVOT_LEFT       = 4'd1,
        CMD_RIGHT_CHOREO     = 4'd2,
        CMD_LEFT_CHOREO      = 4'd3,
        CMD_FORWARD          = 4'd4,
        CMD_VEER_RIGHT       = 4'd5,
        CMD_VEER_LEFT        = 4'd6,
        CMD_GO               = 4'd7,
        CMD_FULL_PIVOT_RIGHT = 4'd8,
        CMD_FULL_PIVOT_LEFT  = 4'd9
    } steer_code_t;

    // Zones visited by the frame-end evaluation.
    typedef enum logic [1:0] {
        ZONE_TOP    = 2'd0,
        ZONE_LEFT   = 2'd1,
        ZONE_RIGHT  = 2'd2,
        ZONE_MIDDLE = 2'd3
    } zone_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_AREA   = 2'd1,
        ST_CMP    = 2'd2,
        ST_DECIDE = 2'd3
    } state_t;

    // Configuration register contents.
    typedef struct packed {
        logic [PIXEL_W-1:0] bright_level;
        logic [DIM_W-1:0]   top_band_rows;
        logic [DIM_W-1:0]   side_band_cols;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [FRAC_W-1:0]  side_fraction_q10;
        logic [FRAC_W-1:0]  top_fraction_q10;
        logic [COUNT_W-1:0] middle_pixel_count;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  pixel_en;
        logic  resume_en;
        logic  area_en;
        logic  cmp_en;
        zone_t zone;
        logic  decide_en;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;
    } dp_status_t;

    // Saturating increment of a bright count.
    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
        count_up = (c < COUNT_MAX) ? c + 1'b1 : c;
    endfunction

endpackage

>>> hw/rtl/bzsd_cfg.sv
// Configuration register file of the bright zone steering decider.
module bzsd_cfg
    import bzsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index into the selected register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS: cfg_next.bright_level         = cfg_data[PIXEL_W-1:0];
                REG_TOP_ROWS:   cfg_next.top_band_rows        = cfg_data[DIM_W-1:0];
                REG_SIDE_COLS:  cfg_next.side_band_cols       = cfg_data[DIM_W-1:0];
                REG_WIDTH:      cfg_next.frame_width          = cfg_data[DIM_W-1:0];
                REG_HEIGHT:     cfg_next.frame_height         = cfg_data[DIM_W-1:0];
                REG_SIDE_FRAC:  cfg_next.side_fraction_q10    = cfg_data[FRAC_W-1:0];
                REG_TOP_FRAC:   cfg_next.top_fraction_q10     = cfg_data[FRAC_W-1:0];
                REG_MIDDLE_CNT: cfg_next.middle_pixel_count   = cfg_data[COUNT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bright_level         <= RST_BRIGHTNESS;
            cfg_reg.top_band_rows        <= RST_TOP_ROWS;
            cfg_reg.side_band_cols       <= RST_SIDE_COLS;
            cfg_reg.frame_width          <= RST_WIDTH;
            cfg_reg.frame_height         <= RST_HEIGHT;
            cfg_reg.side_fraction_q10    <= RST_SIDE_FRAC;
            cfg_reg.top_fraction_q10     <= RST_TOP_FRAC;
            cfg_reg.middle_pixel_count   <= RST_MIDDLE_CNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/bzsd_ctrl.sv
// Controller state machine: input handshake and the frame-end evaluation sequence.
module bzsd_ctrl
    import bzsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_stall,
    input  logic       mode,
    input  logic       frame_end,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    zone_t  zone_reg;
    zone_t  zone_next;

    // State and zone registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            zone_reg  <= ZONE_TOP;
        end
        else
        begin
            state_reg <= state_next;
            zone_reg  <= zone_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        zone_next     = zone_reg;
        pixel_stall   = 1'b1;
        cmd.pixel_en  = 1'b0;
        cmd.resume_en = 1'b0;
        cmd.area_en   = 1'b0;
        cmd.cmp_en    = 1'b0;
        cmd.zone      = zone_reg;
        cmd.decide_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pixel_stall = 1'b0;
                if (pixel_valid)
                begin
                    if (mode)
                    begin
                        cmd.resume_en = 1'b1;
                    end
                    else
                    begin
                        cmd.pixel_en = 1'b1;
                        if (frame_end)
                        begin
                            zone_next  = ZONE_TOP;
                            state_next = ST_AREA;
                        end
                    end
                end
            end
            ST_AREA:
            begin
                cmd.area_en = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp_en = 1'b1;
                if (zone_reg == ZONE_MIDDLE)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    zone_next  = zone_t'(zone_reg + 2'd1);
                    state_next = ST_AREA;
                end
            end
            ST_DECIDE:
            begin
                // Hold the new result until the output register is free.
                if (!status.out_full)
                begin
                    cmd.decide_en = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/bzsd_dp.sv
// Datapath: position tracking, zone counters, shared area multiplier and decision logic.
module bzsd_dp
    import bzsd_pkg::*;
#(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic [PIXEL_W-1:0] pixel,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         zone_flags,
    output logic               command_valid,
    output logic [3:0]         command_code
);

    localparam int CW     = $clog2(MAX_FRAME_DIM);
    localparam int DW     = (CW + 1 > DIM_W + 1) ? CW + 1 : DIM_W + 1;
    localparam int PROD_W = COUNT_W + DIM_W;
    localparam int RHS_W  = FRAC_W + AREA_W;
    localparam int LHS_W  = COUNT_W + FRACTION_BITS;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      row_reg;
    logic [COUNT_W-1:0] top_cnt_reg;
    logic [COUNT_W-1:0] left_cnt_reg;
    logic [COUNT_W-1:0] right_cnt_reg;
    logic [COUNT_W-1:0] mid_cnt_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [3:0]         over_reg;
    logic               listening_reg;
    logic               favor_reg;
    logic               out_valid_reg;
    logic [2:0]         zone_flags_reg;
    logic               command_valid_reg;
    logic [3:0]         command_code_reg;

    // Position and zone membership of the current pixel.
    logic [DW-1:0] col_w, row_w, width_w, side_w, top_w, wrap_w;
    logic          in_top, in_left, in_right, bright, col_last;

    always_comb
    begin
        col_w   = DW'(col_reg);
        row_w   = DW'(row_reg);
        width_w = DW'(cfg.frame_width);
        side_w  = DW'(cfg.side_band_cols);
        top_w   = DW'(cfg.top_band_rows);
        if (width_w == '0)
            wrap_w = DW'(1);
        else if (width_w > DW'(MAX_FRAME_DIM))
            wrap_w = DW'(MAX_FRAME_DIM);
        else
            wrap_w = width_w;
        col_last = (col_w + DW'(1)) >= wrap_w;
        in_top   = row_w < top_w;
        in_left  = col_w < side_w;
        in_right = (side_w <= width_w) && (col_w > (width_w - side_w));
        bright   = pixel > cfg.bright_level;
    end

    // Position counters and bright counts; cleared after each frame decision.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            top_cnt_reg   <= '0;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            mid_cnt_reg   <= '0;
        end
        else if (cmd.decide_en)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            top_cnt_reg   <= '0;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            mid_cnt_reg   <= '0;
        end
        else if (cmd.pixel_en)
        begin
            if (bright && in_top)
                top_cnt_reg <= count_up(top_cnt_reg);
            if (bright && in_left)
                left_cnt_reg <= count_up(left_cnt_reg);
            if (bright && in_right)
                right_cnt_reg <= count_up(right_cnt_reg);
            if (bright && !(in_top || in_left || in_right))
                mid_cnt_reg <= count_up(mid_cnt_reg);
            if (col_last)
            begin
                col_reg <= '0;
                if (row_reg < CW'(MAX_FRAME_DIM - 1))
                    row_reg <= row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Operand selection for the shared area multiplier and the compare.
    logic [COUNT_W-1:0] mul_a;
    logic [DIM_W-1:0]   mul_b;
    logic [PROD_W-1:0]  area_prod;
    logic [COUNT_W-1:0] sel_count;
    logic [FRAC_W-1:0]  sel_frac;
    logic [RHS_W-1:0]   rhs_prod;
    logic [CMP_W-1:0]   lhs_w, rhs_w;

    always_comb
    begin
        case (cmd.zone)
            ZONE_TOP:
            begin
                mul_a     = COUNT_W'(cfg.frame_width);
                mul_b     = cfg.top_band_rows;
                sel_count = top_cnt_reg;
                sel_frac  = cfg.top_fraction_q10;
            end
            ZONE_LEFT:
            begin
                mul_a     = COUNT_W'(cfg.frame_height);
                mul_b     = cfg.side_band_cols;
                sel_count = left_cnt_reg;
                sel_frac  = cfg.side_fraction_q10;
            end
            ZONE_RIGHT:
            begin
                mul_a     = COUNT_W'(cfg.frame_height);
                mul_b     = cfg.side_band_cols;
                sel_count = right_cnt_reg;
                sel_frac  = cfg.side_fraction_q10;
            end
            default:
            begin
                mul_a     = cfg.middle_pixel_count;
                mul_b     = DIM_W'(1);
                sel_count = mid_cnt_reg;
                sel_frac  = cfg.top_fraction_q10;
            end
        endcase
        area_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
        rhs_prod  = RHS_W'(sel_frac) * RHS_W'(area_reg);
        lhs_w     = CMP_W'({sel_count, {FRACTION_BITS{1'b0}}});
        rhs_w     = CMP_W'(rhs_prod);
    end

    // Area register, then the cross-multiplied compare in the following cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.area_en)
            area_reg <= area_prod[AREA_W-1:0];
        if (cmd.cmp_en)
            over_reg[cmd.zone] <= lhs_w > rhs_w;
    end

    // Steering decision from the four zone flags.
    logic        t_f, l_f, r_f, m_f;
    logic [3:0]  code;
    logic        listening_next;
    logic        favor_next;

    always_comb
    begin
        t_f = over_reg[ZONE_TOP];
        l_f = over_reg[ZONE_LEFT];
        r_f = over_reg[ZONE_RIGHT];
        m_f = over_reg[ZONE_MIDDLE];
        listening_next = listening_reg;
        favor_next     = favor_reg;
        code           = 4'd0;
        if (listening_reg)
        begin
            if (t_f && (l_f == r_f))
            begin
                code = favor_reg ? CMD_PIVOT_RIGHT : CMD_PIVOT_LEFT;
            end
            else if (t_f && l_f)
            begin
                code           = CMD_RIGHT_CHOREO;
                listening_next = 1'b0;
                favor_next     = 1'b1;
            end
            else if (t_f)
            begin
                code           = CMD_LEFT_CHOREO;
                listening_next = 1'b0;
                favor_next     = 1'b0;
            end
            else if (l_f && r_f)
            begin
                code = CMD_FORWARD;
            end
            else if (l_f)
            begin
                code       = CMD_VEER_RIGHT;
                favor_next = 1'b1;
            end
            else if (r_f)
            begin
                code       = CMD_VEER_LEFT;
                favor_next = 1'b0;
            end
            else
            begin
                code = CMD_GO;
            end
            // A bright middle overrides with a full pivot and keeps listening.
            if (m_f)
            begin
                listening_next = 1'b1;
                code = favor_next ? CMD_FULL_PIVOT_RIGHT : CMD_FULL_PIVOT_LEFT;
            end
        end
    end

    // Steering flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listening_reg <= 1'b1;
            favor_reg     <= 1'b0;
        end
        else if (cmd.resume_en)
        begin
            listening_reg <= 1'b1;
        end
        else if (cmd.decide_en)
        begin
            listening_reg <= listening_next;
            favor_reg     <= favor_next;
        end
    end

    // Output register and its valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.decide_en)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide_en)
        begin
            zone_flags_reg    <= {t_f, r_f, l_f};
            command_valid_reg <= listening_reg;
            command_code_reg  <= code;
        end
    end

    assign status.out_full = out_valid_reg && result_stall;
    assign result_valid    = out_valid_reg;
    assign zone_flags      = zone_flags_reg;
    assign command_valid   = command_valid_reg;
    assign command_code    = command_code_reg;

endmodule

>>> hw/rtl/bright_zone_steering_decider_unit.sv
// Top level of the bright zone steering decider.
//
// Pixel and resume requests are taken one per clock while the controller is
// idle; pixel_stall is high during a frame-end evaluation. A frame_end pixel
// request is accepted, then each of the four zones gets an area step on one
// multiplier shared by the zones and a cross-multiplied fraction compare on
// a second shared multiplier, then a decision step loads the result register;
// it waits while an earlier result is still held by a stalled consumer. Only
// a frame_end pixel produces a result. No clearing pass is needed after reset.
module bright_zone_steering_decider_unit
    import bzsd_pkg::*;
#(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic                  mode,
    input  logic [PIXEL_W-1:0]    pixel,
    input  logic                  frame_end,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [2:0]            zone_flags,
    output logic                  command_valid,
    output logic [3:0]            command_code,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration registers.
    bzsd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer.
    bzsd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .mode        (mode),
        .frame_end   (frame_end),
        .status      (status),
        .cmd         (cmd)
    );

    // Counting, compare and decision datapath.
    bzsd_dp #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .pixel         (pixel),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .zone_flags    (zone_flags),
        .command_valid (command_valid),
        .command_code  (command_code)
    );

endmodule

>>> tb/sv/bright_zone_steering_decider_unit_test.sv
// Self-checking testbench for the bright zone steering decider unit.
module bright_zone_steering_decider_unit_test;

    import bzsd_pkg::*;

    // Request kinds carried on the mode input.
    localparam bit REQ_PIXEL  = 1'b0;
    localparam bit REQ_RESUME = 1'b1;

    // Command field of a result given while the unit is not listening.
    localparam logic [3:0] NO_COMMAND = 4'd0;

    // Cycles to let pass after the last result before touching registers.
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PRINT_LIMIT   = 50;

    typedef struct {
        bit                 mode;
        logic [PIXEL_W-1:0] pixel;
        bit                 frame_end;
    } steer_req_t;

    typedef struct {
        logic [2:0] zones;
        logic       cmd_valid;
        logic [3:0] cmd;
    } steer_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    logic                  mode = 1'b0;
    logic [PIXEL_W-1:0]    pixel = '0;
    logic                  frame_end = 1'b0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [2:0]            zone_flags;
    logic                  command_valid;
    logic [3:0]            command_code;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Pending requests, and the decisions expected back in order.
    steer_req_t    pixel_req_q[$];
    steer_result_t decision_q[$];

    int  sender_idle_pct = 0;
    int  stall_pct = 0;
    int  mismatches = 0;
    bit  req_taken = 1'b0;

    // Predicted state of the unit.
    cfg_t               cfg_now;
    logic [10:0]        col_pos = '0;
    logic [10:0]        row_pos = '0;
    logic [COUNT_W-1:0] top_cnt = '0;
    logic [COUNT_W-1:0] left_cnt = '0;
    logic [COUNT_W-1:0] right_cnt = '0;
    logic [COUNT_W-1:0] mid_cnt = '0;
    bit                 listening = 1'b1;
    bit                 favor_right = 1'b0;

    bright_zone_steering_decider_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .mode          (mode),
        .pixel         (pixel),
        .frame_end     (frame_end),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .zone_flags    (zone_flags),
        .command_valid (command_valid),
        .command_code  (command_code),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] c);
        return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // A zone is over its threshold when count / area > frac / 2^10.
    function automatic bit zone_over(logic [COUNT_W-1:0] cnt, logic [FRAC_W-1:0] frac,
                                     longint unsigned area);
        longint unsigned scaled;
        longint unsigned limit;
        scaled = cnt;
        scaled = scaled << FRACTION_BITS_DEF;
        limit = frac;
        limit = limit * area;
        return scaled > limit;
    endfunction

    // Advance the predicted state by one accepted request.
    function automatic void apply_request(bit req_mode, logic [PIXEL_W-1:0] pix,
                                          bit ends_frame);
        int unsigned   width_v;
        int unsigned   side_v;
        int unsigned   wrap_w;
        bit            in_top;
        bit            in_left;
        bit            in_right;
        bit            mid_over;
        logic [3:0]    code;
        steer_result_t res;

        if (req_mode == REQ_RESUME)
        begin
            listening = 1'b1;
            return;
        end

        // Zone membership of the current position, then bright counting.
        width_v = cfg_now.frame_width;
        side_v = cfg_now.side_band_cols;
        in_top = row_pos < cfg_now.top_band_rows;
        in_left = col_pos < cfg_now.side_band_cols;
        in_right = (side_v <= width_v) && (col_pos > width_v - side_v);
        if (pix > cfg_now.bright_level)
        begin
            if (in_top)
                top_cnt = sat_inc(top_cnt);
            if (in_left)
                left_cnt = sat_inc(left_cnt);
            if (in_right)
                right_cnt = sat_inc(right_cnt);
            if (!(in_top || in_left || in_right))
                mid_cnt = sat_inc(mid_cnt);
        end

        // Raster position; the wrap width is clamped, the row saturates.
        if (width_v == 0)
            wrap_w = 1;
        else if (width_v > MAX_FRAME_DIM_DEF)
            wrap_w = MAX_FRAME_DIM_DEF;
        else
            wrap_w = width_v;
        if (col_pos + 1 >= wrap_w)
        begin
            col_pos = '0;
            if (row_pos < MAX_FRAME_DIM_DEF - 1)
                row_pos = row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end

        if (!ends_frame)
            return;

        // Frame-end evaluation of the four zone fractions.
        in_top = zone_over(top_cnt, cfg_now.top_fraction_q10,
                           64'(cfg_now.frame_width) * cfg_now.top_band_rows);
        in_left = zone_over(left_cnt, cfg_now.side_fraction_q10,
                            64'(cfg_now.frame_height) * cfg_now.side_band_cols);
        in_right = zone_over(right_cnt, cfg_now.side_fraction_q10,
                             64'(cfg_now.frame_height) * cfg_now.side_band_cols);
        mid_over = zone_over(mid_cnt, cfg_now.top_fraction_q10,
                             64'(cfg_now.middle_pixel_count));

        res.zones = {in_top, in_right, in_left};
        res.cmd_valid = 1'b0;
        res.cmd = NO_COMMAND;

        // Steering decision, only while listening.
        if (listening)
        begin
            if (in_top && (in_left == in_right))
            begin
                code = favor_right ? CMD_PIVOT_RIGHT : CMD_PIVOT_LEFT;
            end
            else if (in_top && in_left)
            begin
                code = CMD_RIGHT_CHOREO;
                listening = 1'b0;
                favor_right = 1'b1;
            end
            else if (in_top)
            begin
                code = CMD_LEFT_CHOREO;
                listening = 1'b0;
                favor_right = 1'b0;
            end
            else if (in_left && in_right)
            begin
                code = CMD_FORWARD;
            end
            else if (in_left)
            begin
                code = CMD_VEER_RIGHT;
                favor_right = 1'b1;
            end
            else if (in_right)
            begin
                code = CMD_VEER_LEFT;
                favor_right = 1'b0;
            end
            else
            begin
                code = CMD_GO;
            end
            if (mid_over)
            begin
                listening = 1'b1;
                code = favor_right ? CMD_FULL_PIVOT_RIGHT : CMD_FULL_PIVOT_LEFT;
            end
            res.cmd_valid = 1'b1;
            res.cmd = code;
        end
        decision_q.push_back(res);

        col_pos = '0;
        row_pos = '0;
        top_cnt = '0;
        left_cnt = '0;
        right_cnt = '0;
        mid_cnt = '0;
    endfunction

    // Request driver and result stall, both changing on the falling edge.
    always @(negedge clk)
    begin : drive_requests
        steer_req_t nxt;
        if (rst_n && (!pixel_valid || req_taken))
        begin
            if (pixel_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                nxt = pixel_req_q.pop_front();
                pixel_valid <= 1'b1;
                mode <= nxt.mode;
                pixel <= nxt.pixel;
                frame_end <= nxt.frame_end;
            end
            else
            begin
                pixel_valid <= 1'b0;
                mode <= $urandom_range(1);
                pixel <= $urandom_range(255);
                frame_end <= $urandom_range(1);
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: check delivered results, then predict from accepted requests.
    always @(posedge clk)
    begin : watch_ports
        steer_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (decision_q.size() == 0)
                begin
                    report_mismatch("result with nothing pending", zone_flags, -1);
                end
                else
                begin
                    want = decision_q.pop_front();
                    if (zone_flags !== want.zones)
                        report_mismatch("zone_flags", zone_flags, want.zones);
                    if (command_valid !== want.cmd_valid)
                        report_mismatch("command_valid", command_valid, want.cmd_valid);
                    if (command_code !== want.cmd)
                        report_mismatch("command_code", command_code, want.cmd);
                end
            end
            if (pixel_valid && !pixel_stall)
                apply_request(mode, pixel, frame_end);
            req_taken <= pixel_valid && !pixel_stall;
        end
        else
        begin
            req_taken <= 1'b0;
        end
    end

    task automatic queue_req(bit req_mode, logic [PIXEL_W-1:0] pix, bit ends_frame);
        steer_req_t r;
        r.mode = req_mode;
        r.pixel = pix;
        r.frame_end = ends_frame;
        pixel_req_q.push_back(r);
    endtask

    // One register write per falling edge; the model copy keeps the masked value.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        logic [CFG_DATA_W-1:0] data;
        int                    wid;
        case (idx) inside
            REG_BRIGHTNESS: wid = PIXEL_W;
            REG_SIDE_FRAC, REG_TOP_FRAC: wid = FRAC_W;
            REG_MIDDLE_CNT: wid = COUNT_W;
            default: wid = DIM_W;
        endcase
        data = CFG_DATA_W'(value);
        if ($urandom_range(1) == 1)
            data = data | (CFG_DATA_W'($urandom) << wid);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_BRIGHTNESS: cfg_now.bright_level = data[PIXEL_W-1:0];
            REG_TOP_ROWS:   cfg_now.top_band_rows = data[DIM_W-1:0];
            REG_SIDE_COLS:  cfg_now.side_band_cols = data[DIM_W-1:0];
            REG_WIDTH:      cfg_now.frame_width = data[DIM_W-1:0];
            REG_HEIGHT:     cfg_now.frame_height = data[DIM_W-1:0];
            REG_SIDE_FRAC:  cfg_now.side_fraction_q10 = data[FRAC_W-1:0];
            REG_TOP_FRAC:   cfg_now.top_fraction_q10 = data[FRAC_W-1:0];
            default:        cfg_now.middle_pixel_count = data[COUNT_W-1:0];
        endcase
    endtask

    task automatic write_config(cfg_t c);
        write_reg(REG_BRIGHTNESS, c.bright_level);
        write_reg(REG_TOP_ROWS, c.top_band_rows);
        write_reg(REG_SIDE_COLS, c.side_band_cols);
        write_reg(REG_WIDTH, c.frame_width);
        write_reg(REG_HEIGHT, c.frame_height);
        write_reg(REG_SIDE_FRAC, c.side_fraction_q10);
        write_reg(REG_TOP_FRAC, c.top_fraction_q10);
        write_reg(REG_MIDDLE_CNT, c.middle_pixel_count);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Short frames with a per-frame bright density, and resume requests mixed in.
    task automatic queue_frames(int item_goal);
        int                 items;
        int                 frames;
        int                 len;
        int                 bright_pct;
        int unsigned        thr;
        logic [PIXEL_W-1:0] pix;
        items = 0;
        frames = 0;
        thr = cfg_now.bright_level;
        while (items < item_goal || frames < 3)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
            bright_pct = $urandom_range(100);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(24) == 0)
                begin
                    queue_req(REQ_RESUME, $urandom_range(255), $urandom_range(1));
                    items++;
                end
                if ($urandom_range(9) == 0)
                    pix = $urandom_range(255);
                else if ($urandom_range(99) < bright_pct && thr < 255)
                    pix = $urandom_range(255, thr + 1);
                else
                    pix = $urandom_range(thr, 0);
                queue_req(REQ_PIXEL, pix, i == len - 1);
                items++;
            end
            frames++;
        end
    endtask

    // Wait for the driver to empty, then for every result, then for the pipeline.
    task automatic settle();
        int waited;
        while (pixel_req_q.size() != 0 || pixel_valid)
            @(posedge clk);
        waited = 0;
        while (decision_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0:
            begin
                sender_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct = 48;
                stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct = 0;
                stall_pct = 48;
            end
            default:
            begin
                sender_idle_pct = 20;
                stall_pct = 20;
            end
        endcase
    endtask

    initial
    begin : run_phases
        cfg_t       c;
        logic [9:0] dir_seq [22];

        cfg_now.bright_level = RST_BRIGHTNESS;
        cfg_now.top_band_rows = RST_TOP_ROWS;
        cfg_now.side_band_cols = RST_SIDE_COLS;
        cfg_now.frame_width = RST_WIDTH;
        cfg_now.frame_height = RST_HEIGHT;
        cfg_now.side_fraction_q10 = RST_SIDE_FRAC;
        cfg_now.top_fraction_q10 = RST_TOP_FRAC;
        cfg_now.middle_pixel_count = RST_MIDDLE_CNT;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        // Directed part on a 4 x 3 frame with 2-column side bands.
        set_idling(0);
        c.bright_level = 8'd127;
        c.top_band_rows = 12'd1;
        c.side_band_cols = 12'd2;
        c.frame_width = 12'd4;
        c.frame_height = 12'd3;
        c.side_fraction_q10 = 11'd100;
        c.top_fraction_q10 = 11'd100;
        c.middle_pixel_count = 23'd2;
        write_config(c);
        // Entries are {mode, frame_end, pixel}. A single bright top-left pixel
        // turns listening off; the next frame is reported without a command;
        // the first resume request carries frame_end and a bright pixel that are ignored.
        dir_seq = '{
            {REQ_PIXEL, 1'b1, 8'd255},
            {REQ_PIXEL, 1'b1, 8'd0},
            {REQ_RESUME, 1'b1, 8'd255},
            {REQ_PIXEL, 1'b0, 8'd0},
            {REQ_PIXEL, 1'b0, 8'd0},
            {REQ_PIXEL, 1'b0, 8'd0},
            {REQ_PIXEL, 1'b1, 8'd255},
            {REQ_RESUME, 1'b0, 8'd0},
            {REQ_PIXEL, 1'b0, 8'd0},
            {REQ_PIXEL, 1'b0, 8'd0},
            {REQ_PIXEL, 1'b0, 8'd0},
            {REQ_PIXEL, 1'b0, 8'd0},
            {REQ_PIXEL, 1'b0, 8'd255},
            {REQ_PIXEL, 1'b0, 8'd255},
            {REQ_PIXEL, 1'b0, 8'd128},
            {REQ_PIXEL, 1'b1, 8'd127},
            {REQ_PIXEL, 1'b1, 8'd0},
            {REQ_PIXEL, 1'b0, 8'd255},
            {REQ_PIXEL, 1'b0, 8'd255},
            {REQ_PIXEL, 1'b0, 8'd255},
            {REQ_PIXEL, 1'b0, 8'd255},
            {REQ_PIXEL, 1'b1, 8'd255}
        };
        foreach (dir_seq[k])
            queue_req(dir_seq[k][9], dir_seq[k][7:0], dir_seq[k][8]);
        settle();

        // Random phases under changing settings and idling.
        for (int ph = 1; ph <= 9; ph++)
        begin
            set_idling(ph);
            case (ph)
                3:
                begin
                    // Every nonzero pixel bright, zero width, zero-area top and middle zones.
                    c.bright_level = 8'd0;
                    c.top_band_rows = 12'd4095;
                    c.side_band_cols = 12'd4095;
                    c.frame_width = 12'd0;
                    c.frame_height = 12'd4095;
                    c.side_fraction_q10 = 11'd0;
                    c.top_fraction_q10 = 11'd0;
                    c.middle_pixel_count = 23'd0;
                end
                6:
                begin
                    // Nothing bright, widest frame, highest thresholds.
                    c.bright_level = 8'd255;
                    c.top_band_rows = 12'd0;
                    c.side_band_cols = 12'd0;
                    c.frame_width = 12'd4095;
                    c.frame_height = 12'd0;
                    c.side_fraction_q10 = 11'd2047;
                    c.top_fraction_q10 = 11'd2047;
                    c.middle_pixel_count = {COUNT_W{1'b1}};
                end
                8:
                begin
                    // One pixel per row under a deep top band.
                    c.bright_level = $urandom_range(200, 50);
                    c.top_band_rows = 12'd2047;
                    c.side_band_cols = 12'd0;
                    c.frame_width = 12'd1;
                    c.frame_height = 12'd1;
                    c.side_fraction_q10 = $urandom_range(1024);
                    c.top_fraction_q10 = $urandom_range(1024);
                    c.middle_pixel_count = $urandom_range(8, 1);
                end
                default:
                begin
                    c.bright_level = $urandom_range(255);
                    c.frame_width = $urandom_range(12, 1);
                    c.frame_height = $urandom_range(12, 1);
                    c.top_band_rows = $urandom_range(5);
                    c.side_band_cols = $urandom_range(c.frame_width + 1);
                    c.side_fraction_q10 = $urandom_range(1024);
                    c.top_fraction_q10 = $urandom_range(1024);
                    c.middle_pixel_count = $urandom_range(48);
                end
            endcase
            write_config(c);
            queue_frames(40);
            settle();
        end

        if (decision_q.size() != 0)
            report_mismatch("results never delivered", 0, decision_q.size());
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #1600000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
